[src/infix_to_postfix_converter_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter
// ---------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define I2P_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset
`define I2P_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/i2p_pkg.sv]
// ---------------------------------------------------------------------------
// i2p_pkg
// Types and constants shared by the infix-to-postfix converter modules.
// ---------------------------------------------------------------------------
package i2p_pkg;

  localparam int NUM_W  = 31;
  localparam int CHAR_W = 8;

  // Number saturation
  localparam logic [NUM_W-1:0] NUM_MAX      = 31'h7FFF_FFFF;
  // (NUM_MAX - d) / 10 for digits 0..7 and for digits 8..9
  localparam logic [NUM_W-1:0] SAT_LIMIT_LO = 31'd214748364;
  localparam logic [NUM_W-1:0] SAT_LIMIT_HI = 31'd214748363;
  localparam logic [3:0]       DIGIT_SPLIT  = 4'd7;

  // Characters
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_TIMES  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DIVIDE = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [3:0] {
    CMD_IGNORE,
    CMD_LETTER,
    CMD_PLUS,
    CMD_MINUS,
    CMD_TIMES,
    CMD_DIVIDE,
    CMD_LPAREN,
    CMD_RPAREN,
    CMD_END
  } cmd_e;

  // Class of the most recent tokens, for unary minus detection
  typedef enum logic [2:0] {
    TC_NONE,
    TC_VALUE,
    TC_PLUS,
    TC_MINUS,
    TC_TIMES,
    TC_DIVIDE,
    TC_LPAREN,
    TC_RPAREN
  } tclass_e;

  // Operator stack codes
  typedef enum logic [2:0] {
    OPC_PLUS   = 3'd0,
    OPC_MINUS  = 3'd1,
    OPC_TIMES  = 3'd2,
    OPC_DIVIDE = 3'd3,
    OPC_LPAREN = 3'd4
  } opc_e;

  typedef enum logic [1:0] {
    KIND_NUMBER,
    KIND_VARIABLE,
    KIND_OPERATOR,
    KIND_END
  } kind_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_NUM,
    BS_RD,
    BS_ACT,
    BS_FIN
  } bstate_e;

  // One classified item
  typedef struct packed {
    logic              has_num;
    logic [NUM_W-1:0]  num;
    cmd_e              cmd;
    logic [CHAR_W-1:0] letter;
  } entry_t;

  // Front to queue
  typedef struct packed {
    logic   push;
    entry_t entry;
  } qpush_t;

  // Queue to back
  typedef struct packed {
    logic   empty;
    entry_t entry;
  } qhead_t;

  // One postfix token
  typedef struct packed {
    kind_e             kind;
    logic [NUM_W-1:0]  num;
    logic [CHAR_W-1:0] letter;
    logic [1:0]        op;
    logic              neg;
    logic              done;
  } token_t;

endpackage

[src/i2p_front.sv]
// ---------------------------------------------------------------------------
// i2p_front
// Takes characters, builds numbers from digits and classifies the rest into
// commands for the back end.
// ---------------------------------------------------------------------------
module i2p_front import i2p_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CHAR_W-1:0] character_i,
  input  logic              end_of_expression_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              q_full_i,
  output qpush_t            q_push_o
);

  logic [NUM_W-1:0] acc_q, acc_d;
  logic             in_num_q, in_num_d;
  logic             accept;
  logic             is_digit;
  logic [CHAR_W-1:0] digit_full;
  logic [3:0]       digit;
  logic [NUM_W+3:0] acc_x10;
  logic [NUM_W-1:0] sat_limit;
  cmd_e             cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign is_digit   = !end_of_expression_i && (character_i >= CH_0) && (character_i <= CH_9);
  assign digit_full = character_i - CH_0;
  assign digit      = digit_full[3:0];

  // acc * 10 + d as shift-and-add
  assign acc_x10   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                     {{NUM_W{1'b0}}, digit};
  assign sat_limit = (digit > DIGIT_SPLIT) ? SAT_LIMIT_HI : SAT_LIMIT_LO;

  // Classify a non-digit item
  always_comb begin
    cmd = CMD_IGNORE;
    if (end_of_expression_i) begin
      cmd = CMD_END;
    end else if (((character_i >= CH_UP_A) && (character_i <= CH_UP_Z)) ||
                 ((character_i >= CH_LO_A) && (character_i <= CH_LO_Z))) begin
      cmd = CMD_LETTER;
    end else begin
      case (character_i)
        CH_PLUS:   cmd = CMD_PLUS;
        CH_MINUS:  cmd = CMD_MINUS;
        CH_TIMES:  cmd = CMD_TIMES;
        CH_DIVIDE: cmd = CMD_DIVIDE;
        CH_LPAREN: cmd = CMD_LPAREN;
        CH_RPAREN: cmd = CMD_RPAREN;
        default:   cmd = CMD_IGNORE;
      endcase
    end
  end

  // Number accumulator and queue push
  always_comb begin
    acc_d             = acc_q;
    in_num_d          = in_num_q;
    q_push_o.push     = 1'b0;
    q_push_o.entry.has_num = in_num_q;
    q_push_o.entry.num     = acc_q;
    q_push_o.entry.cmd     = cmd;
    q_push_o.entry.letter  = character_i;
    if (accept) begin
      if (is_digit) begin
        in_num_d = 1'b1;
        if (!in_num_q) begin
          acc_d = {{(NUM_W-4){1'b0}}, digit};
        end else if (acc_q > sat_limit) begin
          acc_d = NUM_MAX;
        end else begin
          acc_d = acc_x10[NUM_W-1:0];
        end
      end else begin
        // ignored characters with nothing pending need no back-end work
        q_push_o.push = in_num_q || (cmd != CMD_IGNORE);
        in_num_d      = 1'b0;
        acc_d         = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      in_num_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      in_num_q <= in_num_d;
    end
  end

endmodule

[src/i2p_fifo.sv]
// ---------------------------------------------------------------------------
// i2p_fifo
// Short command queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module i2p_fifo import i2p_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  qpush_t push_i,
  output logic   full_o,
  input  logic   pop_i,
  output qhead_t head_o
);

  entry_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.entry = entries_q[rd_ptr_q];

  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !head_o.empty;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[src/i2p_back.sv]
// ---------------------------------------------------------------------------
// i2p_back
// Executes commands against the operator stack and produces postfix tokens.
// The last token of a command is held back so it can be marked run_last.
// ---------------------------------------------------------------------------
module i2p_back import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qhead_t            head_i,
  output logic              pop_o,
  output logic [1:0]        token_kind_o,
  output logic [NUM_W-1:0]  number_value_o,
  output logic [CHAR_W-1:0] variable_letter_o,
  output logic [1:0]        operator_code_o,
  output logic              negated_o,
  output logic              run_last_o,
  output logic              expression_done_o,
  output logic              stack_overflowed_o,
  output logic              out_valid_o,
  input  logic              out_stall_i
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  // Stack memory, read data registered
  logic [2:0]    stack_mem [STACK_DEPTH];
  logic [2:0]    top_q;
  logic          push_en;
  logic [2:0]    push_code;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] rd_addr, wr_addr;

  bstate_e       state_q, state_d;
  entry_t        cmd_q, cmd_d;
  logic [CW-1:0] count_q, count_d;
  tclass_e       prev_q, prev_d, earlier_q, earlier_d;
  logic          ovf_q, ovf_d;
  logic          first_q, first_d;
  token_t        pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  token_t        out_q, out_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;
  logic          out_v_q, out_v_d;

  logic          out_free, can_step, not_empty, neg;
  logic          emit;
  token_t        emit_tok;

  function automatic tclass_e cmd_class(cmd_e c);
    tclass_e t;
    case (c)
      CMD_PLUS:   t = TC_PLUS;
      CMD_MINUS:  t = TC_MINUS;
      CMD_TIMES:  t = TC_TIMES;
      CMD_DIVIDE: t = TC_DIVIDE;
      CMD_LPAREN: t = TC_LPAREN;
      CMD_RPAREN: t = TC_RPAREN;
      default:    t = TC_VALUE;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] cmd_opcode(cmd_e c);
    logic [2:0] o;
    case (c)
      CMD_PLUS:   o = OPC_PLUS;
      CMD_MINUS:  o = OPC_MINUS;
      CMD_TIMES:  o = OPC_TIMES;
      CMD_DIVIDE: o = OPC_DIVIDE;
      default:    o = OPC_LPAREN;
    endcase
    return o;
  endfunction

  assign cnt_m1  = count_q - CW'(1);
  assign rd_addr = cnt_m1[AW-1:0];
  assign wr_addr = count_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[wr_addr] <= push_code;
    end
    top_q <= stack_mem[rd_addr];
  end

  assign out_free  = !out_v_q || !out_stall_i;
  assign can_step  = !pend_v_q || out_free;
  assign not_empty = (count_q != '0);
  assign neg       = (prev_q == TC_MINUS) &&
                     ((earlier_q == TC_NONE) || (earlier_q == TC_LPAREN));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    prev_d     = prev_q;
    earlier_d  = earlier_q;
    ovf_d      = ovf_q;
    first_d    = first_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    out_v_d    = out_v_q;
    pop_o      = 1'b0;
    push_en    = 1'b0;
    push_code  = cmd_opcode(cmd_q.cmd);
    emit       = 1'b0;
    emit_tok   = '0;

    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      BS_IDLE: begin
        if (!head_i.empty) begin
          pop_o   = 1'b1;
          cmd_d   = head_i.entry;
          first_d = 1'b1;
          state_d = head_i.entry.has_num ? BS_NUM : BS_ACT;
        end
      end

      // pending number, with unary minus check
      BS_NUM: begin
        if (can_step) begin
          emit          = 1'b1;
          emit_tok.kind = KIND_NUMBER;
          emit_tok.num  = cmd_q.num;
          emit_tok.neg  = neg;
          emit_tok.done = (cmd_q.cmd == CMD_END);
          earlier_d     = prev_q;
          prev_d        = TC_VALUE;
          if (neg && not_empty && (top_q == OPC_MINUS)) begin
            count_d = cnt_m1;
            state_d = BS_RD;
          end else begin
            state_d = BS_ACT;
          end
        end
      end

      // wait for the new top of stack
      BS_RD: begin
        state_d = BS_ACT;
      end

      BS_ACT: begin
        if (can_step) begin
          first_d = 1'b0;
          if (first_q && (cmd_q.cmd != CMD_END) && (cmd_q.cmd != CMD_LETTER) &&
              (cmd_q.cmd != CMD_IGNORE)) begin
            earlier_d = prev_q;
            prev_d    = cmd_class(cmd_q.cmd);
          end
          case (cmd_q.cmd)
            CMD_END: begin
              if (not_empty) begin
                // open parentheses left at the end vanish silently
                if (top_q != OPC_LPAREN) begin
                  emit          = 1'b1;
                  emit_tok.kind = KIND_OPERATOR;
                  emit_tok.op   = top_q[1:0];
                  emit_tok.done = 1'b1;
                end
                count_d = cnt_m1;
                state_d = BS_RD;
              end else begin
                if (!pend_v_q) begin
                  emit          = 1'b1;
                  emit_tok.kind = KIND_END;
                  emit_tok.done = 1'b1;
                end
                count_d   = '0;
                prev_d    = TC_NONE;
                earlier_d = TC_NONE;
                state_d   = BS_FIN;
              end
            end
            CMD_LETTER: begin
              emit            = 1'b1;
              emit_tok.kind   = KIND_VARIABLE;
              emit_tok.letter = cmd_q.letter;
              emit_tok.neg    = neg;
              earlier_d       = prev_q;
              prev_d          = TC_VALUE;
              if (neg && not_empty && (top_q == OPC_MINUS)) begin
                count_d = cnt_m1;
              end
              state_d = BS_FIN;
            end
            CMD_PLUS, CMD_MINUS, CMD_TIMES, CMD_DIVIDE: begin
              if (not_empty &&
                  (((cmd_q.cmd == CMD_PLUS || cmd_q.cmd == CMD_MINUS) &&
                    (top_q < OPC_LPAREN)) ||
                   (top_q == OPC_TIMES) || (top_q == OPC_DIVIDE))) begin
                emit          = 1'b1;
                emit_tok.kind = KIND_OPERATOR;
                emit_tok.op   = top_q[1:0];
                count_d       = cnt_m1;
                state_d       = BS_RD;
              end else begin
                if (count_q < DEPTH_C) begin
                  push_en = 1'b1;
                  count_d = count_q + CW'(1);
                end else begin
                  ovf_d = 1'b1;
                end
                state_d = BS_FIN;
              end
            end
            CMD_LPAREN: begin
              if (count_q < DEPTH_C) begin
                push_en = 1'b1;
                count_d = count_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
              state_d = BS_FIN;
            end
            CMD_RPAREN: begin
              if (not_empty && (top_q != OPC_LPAREN)) begin
                emit          = 1'b1;
                emit_tok.kind = KIND_OPERATOR;
                emit_tok.op   = top_q[1:0];
                count_d       = cnt_m1;
                state_d       = BS_RD;
              end else begin
                // unmatched close parenthesis leaves an empty stack alone
                if (not_empty) begin
                  count_d = cnt_m1;
                end
                state_d = BS_FIN;
              end
            end
            default: begin
              state_d = BS_FIN;
            end
          endcase
        end
      end

      // hand over the held token as the last of this command
      BS_FIN: begin
        if (can_step) begin
          if (pend_v_q) begin
            out_d      = pend_q;
            out_last_d = 1'b1;
            out_ovf_d  = ovf_q;
            out_v_d    = 1'b1;
            pend_v_d   = 1'b0;
          end
          if (!head_i.empty) begin
            pop_o   = 1'b1;
            cmd_d   = head_i.entry;
            first_d = 1'b1;
            state_d = head_i.entry.has_num ? BS_NUM : BS_ACT;
          end else begin
            state_d = BS_IDLE;
          end
        end
      end

      default: begin
        state_d = BS_IDLE;
      end
    endcase

    // new token: previous held one moves to the output register
    if (emit) begin
      if (pend_v_q) begin
        out_d      = pend_q;
        out_last_d = 1'b0;
        out_ovf_d  = ovf_q;
        out_v_d    = 1'b1;
      end
      pend_d   = emit_tok;
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      count_q   <= '0;
      prev_q    <= TC_NONE;
      earlier_q <= TC_NONE;
      ovf_q     <= 1'b0;
      first_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      prev_q    <= prev_d;
      earlier_q <= earlier_d;
      ovf_q     <= ovf_d;
      first_q   <= first_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o        = out_v_q;
  assign token_kind_o       = out_q.kind;
  assign number_value_o     = out_q.num;
  assign variable_letter_o  = out_q.letter;
  assign operator_code_o    = out_q.op;
  assign negated_o          = out_q.neg;
  assign expression_done_o  = out_q.done;
  assign run_last_o         = out_last_q;
  assign stack_overflowed_o = out_ovf_q;

endmodule

[src/infix_to_postfix_converter.sv]
// ---------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an ASCII expression stream to postfix tokens.
// ---------------------------------------------------------------------------
// Digits, and ignored characters while no number is pending, are absorbed by
// the front end and cost no back-end time; the front end takes a character
// every cycle while the four-entry command queue has room. In the back end
// every other item passes through BS_ACT and BS_FIN, through BS_NUM when it
// closes a pending number, through BS_RD when that number removes a unary
// minus from the stack, and through BS_RD and BS_ACT for each operator
// popped or open parenthesis dropped by an end item: each pop that is
// followed by another look at the stack waits in BS_RD for the registered
// read of the operator stack memory (STACK_DEPTH entries). Tokens leave
// through an output register, so a stalled output does not stop input
// transfers until the queue fills. The overflow flag is sticky until reset.
module infix_to_postfix_converter import i2p_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CHAR_W-1:0] character_i,
  input  logic              end_of_expression_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic [1:0]        token_kind_o,
  output logic [NUM_W-1:0]  number_value_o,
  output logic [CHAR_W-1:0] variable_letter_o,
  output logic [1:0]        operator_code_o,
  output logic              negated_o,
  output logic              run_last_o,
  output logic              expression_done_o,
  output logic              stack_overflowed_o,
  output logic              out_valid_o,
  input  logic              out_stall_i
);

  qpush_t q_push;
  qhead_t q_head;
  logic   q_full;
  logic   q_pop;

  i2p_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .character_i         (character_i),
    .end_of_expression_i (end_of_expression_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .q_full_i            (q_full),
    .q_push_o            (q_push)
  );

  i2p_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (q_head),
    .pop_o              (q_pop),
    .token_kind_o       (token_kind_o),
    .number_value_o     (number_value_o),
    .variable_letter_o  (variable_letter_o),
    .operator_code_o    (operator_code_o),
    .negated_o          (negated_o),
    .run_last_o         (run_last_o),
    .expression_done_o  (expression_done_o),
    .stack_overflowed_o (stack_overflowed_o),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i)
  );

endmodule

[src/i2p_checker.sv]
// ---------------------------------------------------------------------------
// i2p_checker
// Port-level checks of the converter output stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "infix_to_postfix_converter_macros.svh"

module i2p_checker import i2p_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic [1:0]        token_kind_o,
  input logic [NUM_W-1:0]  number_value_o,
  input logic [CHAR_W-1:0] variable_letter_o,
  input logic [1:0]        operator_code_o,
  input logic              negated_o,
  input logic              run_last_o,
  input logic              expression_done_o,
  input logic              stack_overflowed_o,
  input logic              out_valid_o,
  input logic              out_stall_i
);

  logic ovf_seen_q;
  logic out_xfer;
  logic not_value;

  assign out_xfer  = out_valid_o && !out_stall_i;
  assign not_value = (token_kind_o == KIND_OPERATOR) || (token_kind_o == KIND_END);

  // remember an overflow flag once it has been transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_seen_q <= 1'b0;
    end else if (out_xfer && stack_overflowed_o) begin
      ovf_seen_q <= 1'b1;
    end
  end

  `I2P_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) && $stable(number_value_o) && $stable(variable_letter_o) && $stable(operator_code_o) && $stable(negated_o) && $stable(run_last_o) && $stable(expression_done_o) && $stable(stack_overflowed_o), "stalled output token changed")
  `I2P_ASSERT(a_neg_value_only, clk_i, rst_ni, out_valid_o && not_value |-> !negated_o, "unary minus on a non-value token")
  `I2P_ASSERT(a_end_marker, clk_i, rst_ni, out_valid_o && (token_kind_o == KIND_END) |-> run_last_o && expression_done_o, "end marker not last of a flush")
  `I2P_ASSERT(a_ovf_sticky, clk_i, rst_ni, out_valid_o && ovf_seen_q |-> stack_overflowed_o, "overflow flag dropped")
  `I2P_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (.*);
